// ----- rtl/tpe_pkg.sv -----
// ---------------------------------------------------------------------------
// tpe_pkg
// Shared types and constants for the tree to Prufer code encoder: label width
// and the command and status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package tpe_pkg;

    localparam int LABEL_W = 7;

    typedef struct packed {
        logic ld_capture;
        logic ld_wr_a;
        logic ld_wr_b;
        logic enc_init;
        logic scan_rd;
        logic scan_next;
        logic take_leaf;
        logic no_leaf;
        logic upd_rd;
        logic upd_wr;
        logic emit;
        logic clear_all;
    } t_cmd;

    typedef struct packed {
        logic last_flag;
        logic count_zero;
        logic p_beyond;
        logic is_leaf;
        logic v_ok;
        logic out_free;
        logic final_code;
    } t_status;

endpackage

// ----- rtl/tpe_ctrl.sv -----
// ---------------------------------------------------------------------------
// tpe_ctrl
// Sequencer for edge loading, smallest-leaf scanning, neighbour update and
// code emission. Drives the datapath through a command bundle.
// ---------------------------------------------------------------------------
module tpe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  tpe_pkg::t_status i_sts,
    output logic            o_in_ready,
    output tpe_pkg::t_cmd   o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LD_WA    = 4'd1;
    localparam logic [3:0] S_LD_WB    = 4'd2;
    localparam logic [3:0] S_ENC_INIT = 4'd3;
    localparam logic [3:0] S_SCAN_RD  = 4'd4;
    localparam logic [3:0] S_SCAN_CK  = 4'd5;
    localparam logic [3:0] S_UPD_RD   = 4'd6;
    localparam logic [3:0] S_UPD_WR   = 4'd7;
    localparam logic [3:0] S_EMIT     = 4'd8;
    localparam logic [3:0] S_CLEAR    = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    tpe_pkg::t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.ld_capture = 1'b1;
                    n_state        = S_LD_WA;
                end
            end
            S_LD_WA: begin
                cmd.ld_wr_a = 1'b1;
                n_state     = S_LD_WB;
            end
            S_LD_WB: begin
                cmd.ld_wr_b = 1'b1;
                n_state     = i_sts.last_flag ? S_ENC_INIT : S_IDLE;
            end
            S_ENC_INIT: begin
                if (i_sts.count_zero) begin
                    n_state = S_CLEAR;
                end else begin
                    cmd.enc_init = 1'b1;
                    n_state      = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_sts.p_beyond) begin
                    cmd.no_leaf = 1'b1;
                    n_state     = S_EMIT;
                end else begin
                    cmd.scan_rd = 1'b1;
                    n_state     = S_SCAN_CK;
                end
            end
            S_SCAN_CK: begin
                if (i_sts.is_leaf) begin
                    cmd.take_leaf = 1'b1;
                    n_state       = S_UPD_RD;
                end else begin
                    cmd.scan_next = 1'b1;
                    n_state       = S_SCAN_RD;
                end
            end
            S_UPD_RD: begin
                cmd.upd_rd = 1'b1;
                n_state    = i_sts.v_ok ? S_UPD_WR : S_EMIT;
            end
            S_UPD_WR: begin
                cmd.upd_wr = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = i_sts.final_code ? S_CLEAR : S_SCAN_RD;
                end
            end
            S_CLEAR: begin
                cmd.clear_all = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ----- rtl/tpe_datapath.sv -----
// ---------------------------------------------------------------------------
// tpe_datapath
// Degree and neighbour-xor store with per-entry valid bits, edge and scan
// registers, neighbour update logic and the output register.
// ---------------------------------------------------------------------------
module tpe_datapath #(
    parameter int MAX_NODES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tpe_pkg::t_cmd                i_cmd,
    output tpe_pkg::t_status             o_sts,
    input  logic [tpe_pkg::LABEL_W-1:0]  i_end_a,
    input  logic [tpe_pkg::LABEL_W-1:0]  i_end_b,
    input  logic                         i_last_edge,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [tpe_pkg::LABEL_W-1:0]  o_code_value,
    output logic                         o_last_code
);

    localparam int LW = tpe_pkg::LABEL_W;
    localparam int WW = 2 * LW;
    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam logic [LW-1:0] MAX_LBL = LW'(MAX_NODES);
    localparam logic [LW-1:0] ONE     = LW'(1);
    localparam logic [LW-1:0] TWO     = LW'(2);

    function automatic logic label_ok(input logic [LW-1:0] x);
        return (x != '0) && (x <= MAX_LBL);
    endfunction

    function automatic logic [AW-1:0] idx(input logic [LW-1:0] x);
        logic [LW-1:0] t;
        t = x - ONE;
        return t[AW-1:0];
    endfunction

    // word layout: degree in the upper half, neighbour xor in the lower half
    logic [WW-1:0] r_mem [MAX_NODES];
    logic [MAX_NODES-1:0] r_valid;

    logic [WW-1:0] r_rd0;
    logic [WW-1:0] r_rd1;
    logic          r_vld0;
    logic          r_vld1;
    logic [WW-1:0] r_new_a;

    logic [LW-1:0] r_a;
    logic [LW-1:0] r_b;
    logic          r_last;
    logic [LW-1:0] r_edge_cnt;
    logic [LW-1:0] r_n;
    logic [LW-1:0] r_count;
    logic [LW-1:0] r_k;
    logic [LW-1:0] r_p;
    logic [LW-1:0] r_leaf;
    logic [LW-1:0] r_v;

    logic          r_out_valid;
    logic [LW-1:0] r_out_code;
    logic          r_out_last;

    logic [AW-1:0] rd_addr0;
    logic          rd_en0;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [WW-1:0] wr_data;
    logic          edge_ok;
    logic [WW-1:0] old_a;
    logic [WW-1:0] new_a;
    logic [WW-1:0] old_b;
    logic [WW-1:0] new_b;
    logic [WW-1:0] old_v;
    logic [LW-1:0] deg_v;
    logic [WW-1:0] new_v;
    logic          final_code;

    // read ports
    always_comb begin
        if (i_cmd.ld_capture) begin
            rd_addr0 = idx(i_end_a);
        end else if (i_cmd.scan_rd) begin
            rd_addr0 = idx(r_p);
        end else begin
            rd_addr0 = idx(r_v);
        end
    end

    assign rd_en0 = i_cmd.ld_capture | i_cmd.scan_rd | i_cmd.upd_rd;

    always_ff @(posedge i_clk) begin
        if (rd_en0) begin
            r_rd0  <= r_mem[rd_addr0];
            r_vld0 <= r_valid[rd_addr0];
        end
        if (i_cmd.ld_capture) begin
            r_rd1  <= r_mem[idx(i_end_b)];
            r_vld1 <= r_valid[idx(i_end_b)];
        end
    end

    // edge load and neighbour update
    assign edge_ok = label_ok(r_a) && label_ok(r_b) && (r_edge_cnt < (MAX_LBL - ONE));
    assign old_a   = r_vld0 ? r_rd0 : '0;
    assign new_a   = {old_a[WW-1:LW] + ONE, old_a[LW-1:0] ^ r_b};
    assign old_b   = (r_a == r_b) ? r_new_a : (r_vld1 ? r_rd1 : '0);
    assign new_b   = {old_b[WW-1:LW] + ONE, old_b[LW-1:0] ^ r_a};

    // leaf entry already dropped when the neighbour is the leaf itself
    assign old_v = ((r_v == r_leaf) || !r_vld0) ? '0 : r_rd0;
    assign deg_v = (old_v[WW-1:LW] != '0) ? (old_v[WW-1:LW] - ONE) : '0;
    assign new_v = {deg_v, old_v[LW-1:0] ^ r_leaf};

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx(r_v);
        wr_data = new_v;
        if (i_cmd.ld_wr_a) begin
            wr_en   = edge_ok;
            wr_addr = idx(r_a);
            wr_data = new_a;
        end else if (i_cmd.ld_wr_b) begin
            wr_en   = edge_ok;
            wr_addr = idx(r_b);
            wr_data = new_b;
        end else if (i_cmd.upd_wr) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.clear_all) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end else if (i_cmd.upd_rd) begin
            r_valid[idx(r_leaf)] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_cnt <= '0;
            r_leaf     <= '0;
        end else if (i_cmd.clear_all) begin
            r_edge_cnt <= '0;
            r_leaf     <= '0;
        end else begin
            if (i_cmd.ld_wr_b && edge_ok) begin
                r_edge_cnt <= r_edge_cnt + ONE;
            end
            if (i_cmd.take_leaf) begin
                r_leaf <= r_p;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_capture) begin
            r_a    <= i_end_a;
            r_b    <= i_end_b;
            r_last <= i_last_edge;
        end
        if (i_cmd.ld_wr_a) begin
            r_new_a <= new_a;
        end
        if (i_cmd.enc_init) begin
            r_n     <= r_edge_cnt + ONE;
            r_count <= r_edge_cnt - ONE;
            r_k     <= '0;
        end else if (i_cmd.emit) begin
            r_k <= r_k + ONE;
        end
        if (i_cmd.take_leaf) begin
            r_v <= r_rd0[LW-1:0];
        end else if (i_cmd.no_leaf) begin
            r_v <= '0;
        end
        if (i_cmd.enc_init) begin
            r_p <= ONE;
        end else if (i_cmd.scan_next) begin
            r_p <= r_p + ONE;
        end else if (i_cmd.upd_rd) begin
            r_p <= r_leaf + ONE;
        end else if (i_cmd.upd_wr && (deg_v == ONE) && (r_v < r_leaf)) begin
            r_p <= r_v;
        end
    end

    // output register
    assign final_code = ((r_k + ONE) == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_code <= r_v;
            r_out_last <= final_code;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_value = r_out_code;
    assign o_last_code  = r_out_last;

    assign o_sts.last_flag  = r_last;
    assign o_sts.count_zero = (r_edge_cnt < TWO);
    assign o_sts.p_beyond   = (r_p > r_n);
    assign o_sts.is_leaf    = r_vld0 && (r_rd0[WW-1:LW] == ONE);
    assign o_sts.v_ok       = label_ok(r_v);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_sts.final_code = final_code;

endmodule

// ----- rtl/tree_to_prufer_encoder_top.sv -----
// ---------------------------------------------------------------------------
// tree_to_prufer_encoder_top
// Loads the edges of a labelled tree and emits its Prufer code.
//
// Input channel (i_in_valid / o_in_ready): one edge per beat, labels 1 to
// MAX_NODES; i_last_edge on the final edge starts encoding. Each edge first
// reads both endpoint entries from the store, then writes one endpoint at a
// time through the single write port.
// Output channel (o_out_valid / i_out_ready): N-2 code beats, the final one
// with o_last_code set; a tree of fewer than three vertices gives none.
// Encoding takes a set-up step, then walks the store upward for the smallest
// leaf with a registered read and then a check per entry; a removal adds a
// neighbour read, a neighbour write (for a valid neighbour) and an emit. The
// walk resumes above the removed leaf or drops back to a neighbour that
// became a smaller leaf; the state after the final beat clears the store.
// The code beat sits in an output register: a stalled receiver holds the
// encoder in its emit step, and the next tree's first edge is taken while
// the final code beat still waits. Reset empties the store at once through
// per-entry valid bits, drops any pending beat and returns to edge loading.
// ---------------------------------------------------------------------------
module tree_to_prufer_encoder_top #(
    parameter int MAX_NODES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [tpe_pkg::LABEL_W-1:0]  i_end_a,
    input  logic [tpe_pkg::LABEL_W-1:0]  i_end_b,
    input  logic                         i_last_edge,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [tpe_pkg::LABEL_W-1:0]  o_code_value,
    output logic                         o_last_code
);

    tpe_pkg::t_cmd    cmd;
    tpe_pkg::t_status sts;

    tpe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    tpe_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_end_a      (i_end_a),
        .i_end_b      (i_end_b),
        .i_last_edge  (i_last_edge),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_code_value (o_code_value),
        .o_last_code  (o_last_code)
    );

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.ld_wr_a, cmd.ld_wr_b, cmd.upd_wr}))
        else $error("more than one store write source");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.out_free)
        else $error("code beat loaded over a pending beat");

    a_busy_after_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("edge beat accepted while loading");

endmodule

// ----- verif/tpe_code_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tpe_code_checker
// Watches both channels of the tree to Prufer encoder. Accepted edge beats
// feed a local copy of the degree and neighbour-xor stores; the beat that
// closes a tree runs the smallest-leaf removal and queues the expected codes.
// Each accepted code beat is compared field by field with the oldest entry.
// ---------------------------------------------------------------------------
module tpe_code_checker #(
    parameter int MAX_NODES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [tpe_pkg::LABEL_W-1:0]  i_end_a,
    input  logic [tpe_pkg::LABEL_W-1:0]  i_end_b,
    input  logic                         i_last_edge,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [tpe_pkg::LABEL_W-1:0]  i_code_value,
    input  logic                         i_last_code,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_tree_count,
    output int                           o_code_count
);

    typedef logic [tpe_pkg::LABEL_W-1:0] t_label;

    typedef struct packed {
        t_label code;
        logic   last;
    } t_code_beat;

    t_label     degree [1:MAX_NODES];
    t_label     nbr_xor [1:MAX_NODES];
    int         edges_held;
    t_code_beat expected_codes [$];
    t_code_beat beat;

    function automatic bit in_range(input t_label v);
        return v >= 1 && v <= MAX_NODES;
    endfunction

    function automatic void wipe_tree();
        for (int i = 1; i <= MAX_NODES; i++) begin
            degree[i]  = '0;
            nbr_xor[i] = '0;
        end
        edges_held = 0;
    endfunction

    task automatic report(input string what);
        if (o_fail_count < 40) begin
            $display("%0t mismatch at code beat %0d: %s", $time, o_code_count, what);
        end
        o_fail_count++;
    endtask

    task automatic absorb_edge(input t_label a, input t_label b, input logic last);
        int         n;
        int         count;
        int         leaf;
        int         k;
        int         x;
        t_label     v;
        t_code_beat nb;
        if (in_range(a) && in_range(b) && edges_held < MAX_NODES - 1) begin
            degree[a]  = degree[a] + 1'b1;
            degree[b]  = degree[b] + 1'b1;
            nbr_xor[a] = nbr_xor[a] ^ b;
            nbr_xor[b] = nbr_xor[b] ^ a;
            edges_held++;
        end
        if (last) begin
            o_tree_count++;
            n     = edges_held + 1;
            count = (n >= 3) ? n - 2 : 0;
            for (k = 0; k < count; k++) begin
                leaf = 0;
                v    = '0;
                for (x = 1; x <= n && leaf == 0; x++) begin
                    if (degree[x] == 1) leaf = x;
                end
                if (leaf != 0) begin
                    v             = nbr_xor[leaf];
                    degree[leaf]  = '0;
                    nbr_xor[leaf] = '0;
                    if (in_range(v)) begin
                        if (degree[v] != 0) degree[v] = degree[v] - 1'b1;
                        nbr_xor[v] = nbr_xor[v] ^ t_label'(leaf);
                    end
                end
                nb.code        = v;
                nb.last        = (k == count - 1);
                expected_codes = {expected_codes, nb};
            end
            wipe_tree();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wipe_tree();
            expected_codes.delete();
        end else begin
            if ($isunknown(i_out_valid)) report("output valid unknown");
            if (i_out_valid && i_out_ready) begin
                o_code_count++;
                if (expected_codes.size() == 0) begin
                    report($sformatf("beat with nothing outstanding, code %0d", i_code_value));
                end else begin
                    beat = expected_codes.pop_front();
                    if (i_code_value !== beat.code) begin
                        report($sformatf("code %0d, expected %0d", i_code_value, beat.code));
                    end
                    if (i_last_code !== beat.last) begin
                        report($sformatf("last flag %b, expected %b", i_last_code, beat.last));
                    end
                end
            end
            if (i_in_valid && i_in_ready) absorb_edge(i_end_a, i_end_b, i_last_edge);
        end
        o_pending <= expected_codes.size();
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the tree to Prufer encoder. Sends a short set of hand-picked
// edge lists, then random labelled trees with some malformed edge lists mixed
// in, through four idle modes and a long receiver hold-off. The checker
// predicts every code beat; this module makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int NODES        = 64;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 60;

    typedef logic [tpe_pkg::LABEL_W-1:0] t_label;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    t_label end_a;
    t_label end_b;
    logic   last_edge;
    logic   out_valid;
    logic   out_ready;
    t_label code_value;
    logic   last_code;
    logic   hold_req;
    int     send_idle;
    int     recv_stall;
    int     beats_sent;
    int     fails;
    int     pending;
    int     trees;
    int     codes;

    tree_to_prufer_encoder_top #(
        .MAX_NODES (NODES)
    ) i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_end_a      (end_a),
        .i_end_b      (end_b),
        .i_last_edge  (last_edge),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_code_value (code_value),
        .o_last_code  (last_code)
    );

    tpe_code_checker #(
        .MAX_NODES (NODES)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_end_a      (end_a),
        .i_end_b      (end_b),
        .i_last_edge  (last_edge),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_code_value (code_value),
        .i_last_code  (last_code),
        .o_fail_count (fails),
        .o_pending    (pending),
        .o_tree_count (trees),
        .o_code_count (codes)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // receiver, with one long hold-off on request
    initial begin
        int held;
        bit hold_done;
        out_ready = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                held      = 0;
                while (held < HOLD_CYCLES) begin
                    out_ready <= 1'b0;
                    @(negedge clk);
                    held++;
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    function automatic t_label pick_label();
        if ($urandom_range(0, 9) == 0) return t_label'($urandom_range(0, 127));
        return t_label'($urandom_range(1, 6));
    endfunction

    task automatic send_edge(input t_label a, input t_label b, input logic last);
        while ($urandom_range(0, 99) < send_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        end_a     <= a;
        end_b     <= b;
        last_edge <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    // random tree on labels 1..nv, edges shuffled, extra edges past the end
    task automatic send_tree(input int nv, input int extra);
        int     perm [1:NODES];
        t_label ea [$];
        t_label eb [$];
        t_label tmp;
        int     j;
        int     t;
        int     p;
        for (j = 1; j <= nv; j++) perm[j] = j;
        for (j = nv; j > 1; j--) begin
            t       = $urandom_range(1, j);
            p       = perm[j];
            perm[j] = perm[t];
            perm[t] = p;
        end
        for (j = 2; j <= nv; j++) begin
            p = $urandom_range(1, j - 1);
            if ($urandom_range(0, 1)) begin
                ea = {ea, t_label'(perm[j])};
                eb = {eb, t_label'(perm[p])};
            end else begin
                ea = {ea, t_label'(perm[p])};
                eb = {eb, t_label'(perm[j])};
            end
        end
        for (j = ea.size() - 1; j > 0; j--) begin
            t     = $urandom_range(0, j);
            tmp   = ea[j];
            ea[j] = ea[t];
            ea[t] = tmp;
            tmp   = eb[j];
            eb[j] = eb[t];
            eb[t] = tmp;
        end
        for (j = 0; j < extra; j++) begin
            ea = {ea, t_label'($urandom_range(1, NODES))};
            eb = {eb, t_label'($urandom_range(1, NODES))};
        end
        if (ea.size() == 0) begin
            ea = {ea, t_label'(0)};
            eb = {eb, t_label'($urandom_range(0, 127))};
        end
        for (j = 0; j < ea.size(); j++) send_edge(ea[j], eb[j], j == ea.size() - 1);
    endtask

    task automatic wait_for_codes();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    initial begin
        int phase;
        int r;
        int sz;
        int j;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        end_a      = '0;
        end_b      = '0;
        last_edge  = 1'b0;
        hold_req   = 1'b0;
        send_idle  = 0;
        recv_stall = 0;
        beats_sent = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // single vertex: dropped edge carries the last mark
        send_edge(7'd0, 7'd5, 1'b1);
        // two vertices
        send_edge(7'd1, 7'd2, 1'b1);
        send_edge(7'd64, 7'd64, 1'b1);
        // three vertices
        send_edge(7'd2, 7'd1, 1'b0);
        send_edge(7'd3, 7'd1, 1'b1);
        // parallel edges, no leaf to be found
        send_edge(7'd1, 7'd2, 1'b0);
        send_edge(7'd1, 7'd2, 1'b1);
        // out of range labels mid-tree
        send_edge(7'd1, 7'd2, 1'b0);
        send_edge(7'd127, 7'd3, 1'b0);
        send_edge(7'd65, 7'd1, 1'b0);
        send_edge(7'd2, 7'd3, 1'b1);
        // self loop
        send_edge(7'd1, 7'd2, 1'b0);
        send_edge(7'd2, 7'd2, 1'b0);
        send_edge(7'd2, 7'd3, 1'b1);
        // star
        send_edge(7'd4, 7'd1, 1'b0);
        send_edge(7'd4, 7'd2, 1'b0);
        send_edge(7'd4, 7'd3, 1'b0);
        send_edge(7'd4, 7'd5, 1'b1);
        // last mark on a dropped edge
        send_edge(7'd1, 7'd2, 1'b0);
        send_edge(7'd2, 7'd3, 1'b0);
        send_edge(7'd0, 7'd0, 1'b1);
        wait_for_codes();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle  = 0;
                    recv_stall <= 0;
                end
                1: begin
                    send_idle  = 85;
                    recv_stall <= 0;
                end
                2: begin
                    send_idle  = 0;
                    recv_stall <= 85;
                end
                default: begin
                    send_idle  = 17;
                    recv_stall <= 17;
                end
            endcase
            if (phase == 0) begin
                // receiver held off while full-size and small trees keep coming
                hold_req <= 1'b1;
                send_tree(NODES, 0);
                send_tree(6, 0);
                send_tree(4, 0);
            end
            if (phase == 2) send_tree(NODES, 4);
            while (beats_sent < 21 + 107 * (phase + 1)) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    r = $urandom_range(0, 99);
                    if (r < 8) sz = $urandom_range(1, 2);
                    else if (r < 75) sz = $urandom_range(3, 10);
                    else if (r < 95) sz = $urandom_range(11, 24);
                    else sz = $urandom_range(25, 40);
                    send_tree(sz, 0);
                end else begin
                    sz = $urandom_range(1, 8);
                    for (j = 0; j < sz; j++) send_edge(pick_label(), pick_label(), j == sz - 1);
                end
            end
            wait_for_codes();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("covered %0d edge beats over %0d trees and %0d code beats", beats_sent, trees,
                 codes);
        $display("idle modes: none, sender 85%%, receiver 85%%, both 17%%; hold-off %0d cycles",
                 HOLD_CYCLES);
        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
